[rtl/lrb_pkg.sv]
// ----------------------------------------------------------------------------
// lrb_pkg
// shared types and constants for the line receive buffer
// ----------------------------------------------------------------------------
package lrb_pkg;

   localparam int BUFFER_DEPTH = 64;
   localparam int ADDR_W       = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
   localparam logic [ADDR_W-1:0] LAST_POS = ADDR_W'(BUFFER_DEPTH - 1);

   localparam logic [7:0] CHAR_CR  = 8'h0D;
   localparam logic [7:0] CHAR_LF  = 8'h0A;
   localparam logic [7:0] CHAR_NUL = 8'h00;

   typedef enum logic {
      OP_RECEIVE = 1'b0,
      OP_READ    = 1'b1
   } lrb_opcode_type;

   typedef struct packed {
      lrb_opcode_type opcode;
      logic [7:0]     rx_byte;
   } lrb_item_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       line_ready;
   } lrb_result_type;

endpackage

[rtl/lrb_ram.sv]
// ----------------------------------------------------------------------------
// lrb_ram
// generic single write port ram with registered read, read-first on collision
// ----------------------------------------------------------------------------
module lrb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/lrb_line_ctrl.sv]
// ----------------------------------------------------------------------------
// lrb_line_ctrl
// line state, write and read positions, buffer store with prefetched read byte
// ----------------------------------------------------------------------------
module lrb_line_ctrl import lrb_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           fire,
   input  lrb_item_type   item,
   output lrb_result_type result
);

   logic [ADDR_W-1:0]       wp_ff, wp_in;
   logic [ADDR_W-1:0]       rp_ff, rp_in;
   logic                    complete_ff, complete_in;
   logic [BUFFER_DEPTH-1:0] filled_ff;
   logic                    fwd_hit_ff;
   logic [7:0]              fwd_data_ff;
   logic                    wr_en;
   logic [7:0]              wr_data;
   logic [7:0]              ram_q;
   logic [7:0]              cur_byte;
   logic [7:0]              read_data;

   // byte at the read position, with last-cycle write forwarded
   assign cur_byte = fwd_hit_ff        ? fwd_data_ff :
                     filled_ff[rp_ff]  ? ram_q       : CHAR_NUL;

   always_comb begin
      wp_in       = wp_ff;
      rp_in       = rp_ff;
      complete_in = complete_ff;
      wr_en       = 1'b0;
      wr_data     = CHAR_NUL;
      read_data   = CHAR_NUL;
      if (fire) begin
         unique case (item.opcode)
            OP_RECEIVE: begin
               if (!complete_ff) begin
                  wr_en = 1'b1;
                  if (item.rx_byte != CHAR_CR && item.rx_byte != CHAR_LF &&
                      wp_ff != LAST_POS) begin
                     wr_data = item.rx_byte;
                     wp_in   = wp_ff + ADDR_W'(1);
                  end else begin
                     wr_data     = CHAR_NUL;
                     wp_in       = '0;
                     complete_in = 1'b1;
                  end
               end
            end
            OP_READ: begin
               if (rp_ff != LAST_POS) begin
                  read_data = cur_byte;
                  if (cur_byte == CHAR_NUL) begin
                     rp_in       = '0;
                     complete_in = 1'b0;
                  end else begin
                     rp_in = rp_ff + ADDR_W'(1);
                  end
               end else begin
                  rp_in       = '0;
                  complete_in = 1'b0;
               end
            end
         endcase
      end
   end

   assign result.read_data  = read_data;
   assign result.line_ready = complete_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff       <= '0;
         rp_ff       <= '0;
         complete_ff <= 1'b0;
         filled_ff   <= '0;
         fwd_hit_ff  <= 1'b0;
      end else begin
         wp_ff       <= wp_in;
         rp_ff       <= rp_in;
         complete_ff <= complete_in;
         fwd_hit_ff  <= wr_en && (wp_ff == rp_in);
         if (wr_en) begin
            filled_ff[wp_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      fwd_data_ff <= wr_data;
   end

   lrb_ram #(
      .WIDTH (8),
      .DEPTH (BUFFER_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wp_ff),
      .wr_data (wr_data),
      .rd_addr (rp_in),
      .rd_data (ram_q)
   );

endmodule

[rtl/line_receive_buffer.sv]
// ----------------------------------------------------------------------------
// line_receive_buffer
// assembles received bytes into one text line and reads it back byte by byte
// ----------------------------------------------------------------------------
// usage
//   req channel: req_opcode selects receive (store req_rx_byte) or read
//   (return next line byte). rsp channel: one item per request, carrying
//   rsp_read_data (zero for receive) and rsp_line_ready.
//   each item passes an input register, then the line logic, then a
//   result register, which drives rsp_valid and the other rsp outputs.
//   one item per cycle is sustained while rsp_stall is low; the read byte
//   is prefetched from the store so a read can follow any item directly.
//   reset clears both positions, the complete mark and the per-entry fill
//   flags at once; unfilled entries read as zero, no clearing pass.
//   when rsp_stall is high with a result waiting, the result register holds,
//   the input register fills, and req_stall rises until the result is taken.
// ----------------------------------------------------------------------------
module line_receive_buffer import lrb_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_opcode,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_read_data,
   output logic       rsp_line_ready
);

   logic           inp_valid_ff;
   lrb_item_type   inp_item_ff;
   logic           out_valid_ff;
   lrb_result_type out_result_ff;
   logic           advance;
   logic           fire;
   logic           accept;
   lrb_result_type result;

   assign advance   = !out_valid_ff || !rsp_stall;
   assign fire      = inp_valid_ff && advance;
   assign req_stall = inp_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         inp_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            out_valid_ff <= inp_valid_ff;
         end
         if (accept) begin
            inp_valid_ff <= 1'b1;
         end else if (fire) begin
            inp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         inp_item_ff.opcode  <= lrb_opcode_type'(req_opcode);
         inp_item_ff.rx_byte <= req_rx_byte;
      end
      if (fire) begin
         out_result_ff <= result;
      end
   end

   lrb_line_ctrl u_line_ctrl (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (inp_item_ff),
      .result (result)
   );

   assign rsp_valid      = out_valid_ff;
   assign rsp_read_data  = out_result_ff.read_data;
   assign rsp_line_ready = out_result_ff.line_ready;

endmodule

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the line receive buffer: directed lines, a line that
// overruns the store, a long result hold-off and random line traffic under
// three idling mixes, each result checked against a shadow of the line store
// ----------------------------------------------------------------------------
module tb import lrb_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 200000;

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic       req_stall;
   logic       req_opcode  = OP_RECEIVE;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall   = 1'b0;
   logic [7:0] rsp_read_data;
   logic       rsp_line_ready;

   logic [7:0]        shadow_store [BUFFER_DEPTH];
   logic [ADDR_W-1:0] shadow_wr;
   logic [ADDR_W-1:0] shadow_rd;
   logic              shadow_done;

   lrb_result_type rsp_due[$];
   int errors        = 0;
   int cycles        = 0;
   int items_counted = 0;
   int send_idle_pct = 0;
   int rsp_idle_pct  = 0;
   int hold_left     = 0;

   line_receive_buffer uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_opcode     (req_opcode),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_read_data  (rsp_read_data),
      .rsp_line_ready (rsp_line_ready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d items outstanding", $time, rsp_due.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   // receiver: random stalls, or a counted hold-off when one is requested
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
      end
   end

   function automatic lrb_result_type next_line_rsp(lrb_opcode_type op, logic [7:0] b);
      lrb_result_type r;
      r.read_data = CHAR_NUL;
      if (op == OP_RECEIVE) begin
         if (!shadow_done) begin
            if (b != CHAR_CR && b != CHAR_LF && shadow_wr != LAST_POS) begin
               shadow_store[shadow_wr] = b;
               shadow_wr = shadow_wr + ADDR_W'(1);
            end else begin
               shadow_store[shadow_wr] = CHAR_NUL;
               shadow_wr = '0;
               shadow_done = 1'b1;
            end
         end
      end else begin
         if (shadow_rd != LAST_POS) begin
            r.read_data = shadow_store[shadow_rd];
            shadow_rd = shadow_rd + ADDR_W'(1);
            if (r.read_data == CHAR_NUL) begin
               shadow_done = 1'b0;
               shadow_rd = '0;
            end
         end else begin
            shadow_done = 1'b0;
            shadow_rd = '0;
         end
      end
      r.line_ready = shadow_done;
      return r;
   endfunction

   function automatic logic [7:0] line_char();
      logic [7:0] c;
      c = ($urandom_range(24) == 0) ? CHAR_NUL : 8'($urandom_range(255));
      while (c == CHAR_CR || c == CHAR_LF)
         c = 8'($urandom_range(255));
      return c;
   endfunction

   // called at a rising edge, returns at a rising edge
   task automatic push_item(lrb_opcode_type op, logic [7:0] b);
      req_valid   <= 1'b1;
      req_opcode  <= op;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      items_counted++;
      rsp_due.push_back(next_line_rsp(op, b));
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (rsp_due.size() != 0)
         @(posedge clock);
   endtask

   always @(posedge clock) begin
      lrb_result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (rsp_due.size() == 0) begin
            $display("%0t: unexpected item, read_data %02h line_ready %0b",
                     $time, rsp_read_data, rsp_line_ready);
            errors++;
         end else begin
            want = rsp_due.pop_front();
            if (rsp_read_data !== want.read_data) begin
               $display("%0t: read_data expected %02h actual %02h",
                        $time, want.read_data, rsp_read_data);
               errors++;
            end
            if (rsp_line_ready !== want.line_ready) begin
               $display("%0t: line_ready expected %0b actual %0b",
                        $time, want.line_ready, rsp_line_ready);
               errors++;
            end
         end
      end
   end

   task automatic test_directed();
      push_item(OP_READ, 8'hFF);
      push_item(OP_RECEIVE, 8'h41);
      push_item(OP_RECEIVE, 8'hFF);
      push_item(OP_RECEIVE, 8'h7F);
      push_item(OP_RECEIVE, CHAR_CR);
      // byte while the line is complete
      push_item(OP_RECEIVE, 8'h55);
      repeat (4) push_item(OP_READ, 8'h00);
      push_item(OP_RECEIVE, CHAR_NUL);
      push_item(OP_RECEIVE, 8'h80);
      push_item(OP_RECEIVE, CHAR_LF);
      push_item(OP_READ, 8'hA5);
      // read with no line complete
      push_item(OP_READ, 8'h5A);
      push_item(OP_RECEIVE, 8'h31);
      push_item(OP_READ, 8'h00);
      push_item(OP_READ, 8'h00);
      push_item(OP_READ, 8'h00);
      push_item(OP_RECEIVE, CHAR_LF);
      push_item(OP_READ, 8'h00);
      push_item(OP_READ, 8'h00);
      wait_drain();
   endtask

   // overrun: last slot takes the terminator, then a read runs off the end
   task automatic test_long_line();
      repeat (BUFFER_DEPTH + 6)
         push_item(OP_RECEIVE, 8'($urandom_range(14, 255)));
      repeat (BUFFER_DEPTH + 2)
         push_item(OP_READ, 8'($urandom_range(255)));
      wait_drain();
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      hold_left     = 40;
      repeat (8) push_item(OP_RECEIVE, line_char());
      push_item(OP_RECEIVE, CHAR_CR);
      repeat (15) push_item(OP_READ, 8'($urandom_range(255)));
      wait_drain();
   endtask

   task automatic test_random_lines(int target);
      int stop_at;
      int len;
      int reads;
      stop_at = items_counted + target;
      while (items_counted < stop_at) begin
         if ($urandom_range(99) < 80) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(40, 70) : $urandom_range(0, 16);
            repeat (len) push_item(OP_RECEIVE, line_char());
            push_item(OP_RECEIVE, $urandom_range(1) ? CHAR_CR : CHAR_LF);
            repeat ($urandom_range(0, 2)) push_item(OP_RECEIVE, 8'($urandom_range(255)));
            if ($urandom_range(3) == 0) begin
               repeat ($urandom_range(0, 6)) push_item(OP_READ, 8'($urandom_range(255)));
            end else begin
               reads = 0;
               while (shadow_done && reads < BUFFER_DEPTH + 2) begin
                  push_item(OP_READ, 8'($urandom_range(255)));
                  reads++;
               end
            end
         end else begin
            repeat ($urandom_range(1, 6)) begin
               if ($urandom_range(1))
                  push_item(OP_READ, 8'($urandom_range(255)));
               else if ($urandom_range(3) == 0)
                  push_item(OP_RECEIVE, $urandom_range(1) ? CHAR_CR : CHAR_LF);
               else
                  push_item(OP_RECEIVE, 8'($urandom_range(255)));
            end
         end
      end
      wait_drain();
   endtask

   initial begin
      foreach (shadow_store[i]) shadow_store[i] = CHAR_NUL;
      shadow_wr   = '0;
      shadow_rd   = '0;
      shadow_done = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_long_line();
      test_backpressure();

      send_idle_pct = 35;
      rsp_idle_pct  = 58;
      test_random_lines(506);
      send_idle_pct = 58;
      rsp_idle_pct  = 35;
      test_random_lines(506);
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      test_random_lines(506);

      repeat (10) @(posedge clock);
      if (rsp_due.size() != 0) begin
         $display("%0t: %0d items never returned", $time, rsp_due.size());
         errors++;
      end
      if (errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
